// ===== rtl/mog_pkg.sv =====
// Shared types, constants and helpers for the metric orthonormal one-form pipeline.
package mog_pkg;

    localparam int Q_SHIFT   = 28;
    localparam int SQ_IN_W   = 59;               // radicand width, D < 2^59
    localparam int SQ_OUT_W  = 30;               // root width
    localparam int RECIP_W   = 31;               // reciprocal quotient width
    localparam int REM_W     = 57;               // holds 2^56
    localparam int DEN_W     = SQ_OUT_W + RECIP_W;
    localparam logic [SQ_OUT_W-1:0] RECIP_SAT_LIM = SQ_OUT_W'(1) << 25;

    localparam logic [1:0] K_X = 2'd0;
    localparam logic [1:0] K_Y = 2'd1;
    localparam logic [1:0] K_Z = 2'd2;

    typedef struct packed {
        logic signed [31:0] form_x;
        logic signed [31:0] form_y;
        logic signed [31:0] form_z;
        logic signed [31:0] inv_xx;
        logic signed [31:0] inv_xy;
        logic signed [31:0] inv_xz;
        logic signed [31:0] inv_yy;
        logic signed [31:0] inv_yz;
        logic signed [31:0] inv_zz;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               bad_norm;
    } t_out;

    typedef struct packed {
        logic signed [31:0] f_x;
        logic signed [31:0] f_y;
        logic signed [31:0] f_z;
        logic        [1:0]  k;
        logic signed [31:0] p;
        logic               bad;
    } t_side;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/mog_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module mog_sqrt import mog_pkg::*; #(
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SQ_IN_W-1:0]  i_x,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output logic [SQ_OUT_W-1:0] o_root,
    output logic [SW-1:0]       o_side
);
    localparam int NS = SQ_OUT_W;

    logic [SQ_IN_W-1:0] r_x   [0:NS];
    logic [SQ_IN_W-1:0] r_res [0:NS];
    logic [SW-1:0]      r_side[0:NS];
    logic               r_v   [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_x[0]    <= i_x;
            r_res[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int B = NS - 1 - j;
        localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (2 * B);
        logic [SQ_IN_W-1:0] trial;
        logic               take;
        logic [SQ_IN_W-1:0] n_x;
        logic [SQ_IN_W-1:0] n_res;

        always_comb begin
            trial = r_res[j] + BIT;
            take  = (r_x[j] >= trial);
            n_x   = take ? (r_x[j] - trial) : r_x[j];
            n_res = take ? ((r_res[j] >> 1) + BIT) : (r_res[j] >> 1);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
            if (i_en) begin
                r_x[j+1]    <= n_x;
                r_res[j+1]  <= n_res;
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_root  = r_res[NS][SQ_OUT_W-1:0];
    assign o_side  = r_side[NS];

endmodule

// ===== rtl/mog_recip.sv =====
// Pipelined reciprocal 2^56 / s, one quotient bit per stage, saturating.
module mog_recip import mog_pkg::*; #(
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SQ_OUT_W-1:0] i_s,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output logic [RECIP_W-1:0]  o_r,
    output logic [SW-1:0]       o_side
);
    localparam int NS = RECIP_W;

    logic [SQ_OUT_W-1:0] r_s   [0:NS];
    logic [REM_W-1:0]    r_rem [0:NS];
    logic [RECIP_W-1:0]  r_q   [0:NS];
    logic                r_sat [0:NS];
    logic [SW-1:0]       r_side[0:NS];
    logic                r_v   [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_s[0]    <= i_s;
            r_rem[0]  <= REM_W'(1) << (REM_W - 1);
            r_q[0]    <= '0;
            r_sat[0]  <= (i_s <= RECIP_SAT_LIM);
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int B = NS - 1 - j;
        logic [DEN_W-1:0]   den;
        logic [DEN_W-1:0]   num;
        logic               take;
        logic [REM_W-1:0]   n_rem;
        logic [RECIP_W-1:0] n_q;

        always_comb begin
            den   = DEN_W'(r_s[j]) << B;
            num   = DEN_W'(r_rem[j]);
            take  = (num >= den);
            n_rem = take ? REM_W'(num - den) : r_rem[j];
            n_q   = take ? (r_q[j] | (RECIP_W'(1) << B)) : r_q[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
            if (i_en) begin
                r_s[j+1]    <= r_s[j];
                r_rem[j+1]  <= n_rem;
                r_q[j+1]    <= n_q;
                r_sat[j+1]  <= r_sat[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_r     = r_sat[NS] ? {RECIP_W{1'b1}} : r_q[NS];
    assign o_side  = r_side[NS];

endmodule

// ===== rtl/metric_orthonormal_oneform_top.sv =====
// Top level: metric Gram-Schmidt step on one grid point per transaction.
//
// Each input transaction carries a unit one-form and the symmetric inverse
// metric (signed Q4.28); each output transaction carries the orthonormalized
// form and a bad_norm flag. The block is a single stalling pipeline that takes
// one transaction every cycle while the output is not stalled. Each
// accepted transaction passes through 72 register stages: five front stages
// (capture, component select, products, projection sum, square of the
// projection), 31 stages of square root (radicand capture, then one root bit
// per stage), 32 stages of reciprocal (operand capture, then one quotient bit
// per stage), and four back stages (p*r, scale, form products, final add and
// saturate). The bit-serial root and reciprocal set that depth. When the
// output is stalled the whole pipeline holds; o_in_ready is high while the
// output slot is free or taken. DIM = 2 ignores every z input; out_z is 0.
module metric_orthonormal_oneform_top import mog_pkg::*; #(
    parameter int DIM = 3
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);
    localparam bit USE_Z = (DIM >= 3);
    localparam int SW    = $bits(t_side);

    logic adv;
    logic r_out_valid;
    t_out r_out;

    // Advance everything whenever the output slot is free or being taken.
    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Stage 0: capture the transaction.
    logic r0_v;
    t_in  r0_in;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (adv) begin
            r0_v <= i_in_valid;
        end
        if (adv) begin
            r0_in <= i_in_data;
        end
    end

    // Stage 1: pick the smallest-magnitude component, lowest index on a tie.
    logic [31:0]        mag_x, mag_y, mag_z;
    logic [1:0]         n1_k;
    logic signed [31:0] n1_g [3];
    logic signed [31:0] n1_f [3];
    always_comb begin
        mag_x = r0_in.form_x[31] ? 32'(-33'(r0_in.form_x)) : r0_in.form_x;
        mag_y = r0_in.form_y[31] ? 32'(-33'(r0_in.form_y)) : r0_in.form_y;
        mag_z = r0_in.form_z[31] ? 32'(-33'(r0_in.form_z)) : r0_in.form_z;
        n1_k  = K_X;
        if (mag_y < mag_x) begin
            n1_k = K_Y;
        end
        if (USE_Z && (mag_z < ((n1_k == K_Y) ? mag_y : mag_x))) begin
            n1_k = K_Z;
        end
        n1_f[0] = r0_in.form_x;
        n1_f[1] = r0_in.form_y;
        n1_f[2] = USE_Z ? r0_in.form_z : 32'sd0;
        unique case (n1_k)
            K_Y: begin
                n1_g[0] = r0_in.inv_xy;
                n1_g[1] = r0_in.inv_yy;
                n1_g[2] = r0_in.inv_yz;
            end
            K_Z: begin
                n1_g[0] = r0_in.inv_xz;
                n1_g[1] = r0_in.inv_yz;
                n1_g[2] = r0_in.inv_zz;
            end
            default: begin
                n1_g[0] = r0_in.inv_xx;
                n1_g[1] = r0_in.inv_xy;
                n1_g[2] = r0_in.inv_xz;
            end
        endcase
    end

    logic               r1_v;
    logic [1:0]         r1_k;
    logic signed [31:0] r1_g [3];
    logic signed [31:0] r1_f [3];
    logic signed [31:0] r1_gkk;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= r0_v;
        end
        if (adv) begin
            r1_k   <= n1_k;
            r1_g   <= n1_g;
            r1_f   <= n1_f;
            r1_gkk <= n1_g[n1_k];
        end
    end

    // Stage 2: row-times-form products (zero z form drops the z term in 2D).
    logic               r2_v;
    logic [1:0]         r2_k;
    logic signed [63:0] r2_prod [3];
    logic signed [31:0] r2_f [3];
    logic signed [31:0] r2_gkk;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_prod[i] <= 64'(r1_g[i]) * 64'(r1_f[i]);
            end
            r2_k   <= r1_k;
            r2_f   <= r1_f;
            r2_gkk <= r1_gkk;
        end
    end

    // Stage 3: projection p, floor-shifted terms summed and saturated.
    logic signed [39:0] n3_sum;
    always_comb begin
        n3_sum = '0;
        for (int i = 0; i < 3; i++) begin
            n3_sum = n3_sum + 40'(r2_prod[i] >>> Q_SHIFT);
        end
    end

    logic               r3_v;
    logic [1:0]         r3_k;
    logic signed [31:0] r3_p;
    logic signed [31:0] r3_f [3];
    logic signed [31:0] r3_gkk;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r2_v;
        end
        if (adv) begin
            r3_p   <= sat32(n3_sum);
            r3_k   <= r2_k;
            r3_f   <= r2_f;
            r3_gkk <= r2_gkk;
        end
    end

    // Stage 4: square the projection.
    logic               r4_v;
    logic [1:0]         r4_k;
    logic signed [31:0] r4_p;
    logic signed [63:0] r4_pp;
    logic signed [31:0] r4_f [3];
    logic signed [31:0] r4_gkk;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv) begin
            r4_v <= r3_v;
        end
        if (adv) begin
            r4_pp  <= 64'(r3_p) * 64'(r3_p);
            r4_p   <= r3_p;
            r4_k   <= r3_k;
            r4_f   <= r3_f;
            r4_gkk <= r3_gkk;
        end
    end

    // Radicand D = g_kk * 2^28 - p^2; not positive flags bad_norm.
    logic signed [64:0] rad;
    logic               rad_bad;
    logic [SQ_IN_W-1:0] sq_x;
    t_side              sq_side_in;
    always_comb begin
        rad     = (65'(r4_gkk) <<< Q_SHIFT) - 65'(r4_pp);
        rad_bad = rad[64] || (rad == 65'sd0);
        sq_x    = rad_bad ? '0 : rad[SQ_IN_W-1:0];
        sq_side_in.f_x = r4_f[0];
        sq_side_in.f_y = r4_f[1];
        sq_side_in.f_z = r4_f[2];
        sq_side_in.k   = r4_k;
        sq_side_in.p   = r4_p;
        sq_side_in.bad = rad_bad;
    end

    logic                sq_v;
    logic [SQ_OUT_W-1:0] sq_root;
    logic [SW-1:0]       sq_side;

    mog_sqrt #(.SW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r4_v),
        .i_x     (sq_x),
        .i_side  (sq_side_in),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // A bad radicand gives root 0; feed 1 instead, the result is dropped anyway.
    logic                rc_v;
    logic [RECIP_W-1:0]  rc_r;
    logic [SW-1:0]       rc_side;

    mog_recip #(.SW(SW)) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (sq_v),
        .i_s     ((sq_root == '0) ? SQ_OUT_W'(1) : sq_root),
        .i_side  (sq_side),
        .o_valid (rc_v),
        .o_r     (rc_r),
        .o_side  (rc_side)
    );

    // Back stage A: p * r.
    t_side              rc_sd;
    assign rc_sd = t_side'(rc_side);

    logic               ra_v;
    t_side              ra_sd;
    logic [RECIP_W-1:0] ra_r;
    logic signed [63:0] ra_pr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v <= 1'b0;
        end else if (adv) begin
            ra_v <= rc_v;
        end
        if (adv) begin
            ra_pr <= 64'(rc_sd.p) * 64'(signed'({1'b0, rc_r}));
            ra_r  <= rc_r;
            ra_sd <= rc_sd;
        end
    end

    // Back stage B: c = sat(floor(-(p*r) / 2^28)).
    logic signed [63:0] neg_pr;
    assign neg_pr = -ra_pr;

    logic               rb_v;
    t_side              rb_sd;
    logic [RECIP_W-1:0] rb_r;
    logic signed [31:0] rb_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_v <= 1'b0;
        end else if (adv) begin
            rb_v <= ra_v;
        end
        if (adv) begin
            rb_c  <= sat32(40'(neg_pr >>> Q_SHIFT));
            rb_r  <= ra_r;
            rb_sd <= ra_sd;
        end
    end

    // Back stage C: scale each form component by c.
    logic               rm_v;
    t_side              rm_sd;
    logic [RECIP_W-1:0] rm_r;
    logic signed [63:0] rm_cf [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_v <= 1'b0;
        end else if (adv) begin
            rm_v <= rb_v;
        end
        if (adv) begin
            rm_cf[0] <= 64'(rb_c) * 64'(rb_sd.f_x);
            rm_cf[1] <= 64'(rb_c) * 64'(rb_sd.f_y);
            rm_cf[2] <= 64'(rb_c) * 64'(rb_sd.f_z);
            rm_r     <= rb_r;
            rm_sd    <= rb_sd;
        end
    end

    // Back stage D: add r on component k, saturate, zero on bad norm.
    logic signed [39:0] rr;
    logic signed [31:0] n_o [3];
    always_comb begin
        rr = 40'(signed'({1'b0, rm_r}));
        for (int i = 0; i < 3; i++) begin
            n_o[i] = sat32(40'(rm_cf[i] >>> Q_SHIFT)
                           + ((rm_sd.k == 2'(i)) ? rr : 40'sd0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= rm_v;
        end
        if (adv) begin
            r_out.bad_norm <= rm_sd.bad;
            r_out.out_x    <= rm_sd.bad ? 32'sd0 : n_o[0];
            r_out.out_y    <= rm_sd.bad ? 32'sd0 : n_o[1];
            r_out.out_z    <= (rm_sd.bad || !USE_Z) ? 32'sd0 : n_o[2];
        end
    end

    // A bad norm always leaves the whole form at zero.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bad_norm |->
            (r_out.out_x == 0) && (r_out.out_y == 0) && (r_out.out_z == 0))
        else $error("bad_norm with nonzero output");

    // Two dimensions never produce a z component.
    a_dim2_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (USE_Z || (r_out.out_z == 0)))
        else $error("out_z nonzero in two dimensions");

    // A held result backs the pipeline up to the input.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");

endmodule
